// ===== src/ysbu_pkg.sv =====
// shared types and constants for the yuv selective background update block
`default_nettype none

package ysbu_pkg;

    // pixel store geometry
    localparam int ADDR_W       = 16;
    localparam int STORE_DEPTH  = 2 ** ADDR_W;
    localparam int FRAME_PIXELS = 65536;

    // largest background value, 255.0 in 8.8
    localparam logic [15:0] BG_MAX = 16'd65280;

    // configuration reset values
    localparam logic [15:0] LUMA_THR_RESET    = 16'd5120;
    localparam logic [15:0] CHROMA_THR_RESET  = 16'd2560;
    localparam logic [15:0] RATE_STATIC_RESET = 16'd6554;
    localparam logic [15:0] RATE_MOVING_RESET = 16'd655;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_LUMA_THR    = 2'd0,
        REG_CHROMA_THR  = 2'd1,
        REG_RATE_STATIC = 2'd2,
        REG_RATE_MOVING = 2'd3
    } reg_idx_t;

    // item commands
    typedef enum logic {
        CMD_PROCESS = 1'b0,
        CMD_LOAD    = 1'b1
    } cmd_t;

    // one background entry, 8.8 per channel
    typedef struct packed {
        logic [15:0] v;
        logic [15:0] u;
        logic [15:0] y;
    } bg_entry_t;

    // control that travels with each pipeline stage
    typedef struct packed {
        logic                valid;
        cmd_t                cmd;
        logic                frame_end;
        logic [ADDR_W-1:0]   addr;
    } ctl_t;

    // differences to the background and their magnitudes
    typedef struct packed {
        logic signed [16:0] dy;
        logic signed [16:0] du;
        logic signed [16:0] dv;
        logic [15:0]        ady;
        logic [31:0]        du2;
        logic [31:0]        dv2;
    } diff_t;

    // background update steps, 8.8
    typedef struct packed {
        logic signed [17:0] sy;
        logic signed [17:0] su;
        logic signed [17:0] sv;
    } step_t;

endpackage

`default_nettype wire

// ===== src/ysbu_yuv.sv =====
// bgr to yuv conversion, luma at entry and chroma one stage later
`default_nettype none

module ysbu_yuv (
    input  logic [7:0] blue,
    input  logic [7:0] green,
    input  logic [7:0] red,
    output logic [7:0] luma,
    input  logic [7:0] stage_blue,
    input  logic [7:0] stage_red,
    input  logic [7:0] stage_luma,
    output logic [7:0] chroma_u,
    output logic [7:0] chroma_v
);

    // 14-bit coefficients and rounding offsets
    localparam logic [21:0]        COEF_R   = 22'd4899;
    localparam logic [21:0]        COEF_G   = 22'd9617;
    localparam logic [21:0]        COEF_B   = 22'd1868;
    localparam logic [21:0]        Y_ROUND  = 22'd8192;
    localparam logic signed [23:0] COEF_U   = 24'sd8061;
    localparam logic signed [23:0] COEF_V   = 24'sd14369;
    localparam logic signed [23:0] UV_OFFS  = 24'sd2105344;

    logic [21:0]        y_sum;
    logic signed [8:0]  b_minus_y;
    logic signed [8:0]  r_minus_y;
    logic signed [23:0] u_sum;
    logic signed [23:0] v_sum;

    // shift by 14 with saturation to 0..255
    function automatic logic [7:0] sat_shr14(input logic signed [23:0] t);
        logic [7:0] res;
        begin
            if (t[23])
                res = 8'd0;
            else if (t[22])
                res = 8'd255;
            else
                res = t[21:14];
            return res;
        end
    endfunction

    // luma: weighted sum, rounded
    assign y_sum = 22'(red) * COEF_R + 22'(green) * COEF_G + 22'(blue) * COEF_B + Y_ROUND;
    assign luma  = y_sum[21:14];

    // chroma from color minus luma
    assign b_minus_y = $signed({1'b0, stage_blue}) - $signed({1'b0, stage_luma});
    assign r_minus_y = $signed({1'b0, stage_red}) - $signed({1'b0, stage_luma});
    assign u_sum     = 24'(b_minus_y) * COEF_U + UV_OFFS;
    assign v_sum     = 24'(r_minus_y) * COEF_V + UV_OFFS;
    assign chroma_u  = sat_shr14(u_sum);
    assign chroma_v  = sat_shr14(v_sum);

endmodule

`default_nettype wire

// ===== src/ysbu_detect.sv =====
// background differences, squared chroma distance and motion decision
`default_nettype none

module ysbu_detect (
    input  logic [7:0]          luma,
    input  logic [7:0]          chroma_u,
    input  logic [7:0]          chroma_v,
    input  ysbu_pkg::bg_entry_t bg,
    output ysbu_pkg::diff_t     diff,
    input  ysbu_pkg::diff_t     stage_diff,
    input  logic [15:0]         luma_threshold,
    input  logic [31:0]         chroma_sq,
    output logic                motion
);

    import ysbu_pkg::*;

    logic signed [16:0] ndy;
    logic signed [33:0] sq_u;
    logic signed [33:0] sq_v;
    logic [32:0]        mag2;

    // signed 8.8 differences
    always_comb
    begin
        diff.dy = $signed({1'b0, luma, 8'd0}) - $signed({1'b0, bg.y});
        diff.du = $signed({1'b0, chroma_u, 8'd0}) - $signed({1'b0, bg.u});
        diff.dv = $signed({1'b0, chroma_v, 8'd0}) - $signed({1'b0, bg.v});
        ndy      = -diff.dy;
        diff.ady = diff.dy[16] ? ndy[15:0] : diff.dy[15:0];
        sq_u     = 34'(diff.du) * 34'(diff.du);
        sq_v     = 34'(diff.dv) * 34'(diff.dv);
        diff.du2 = sq_u[31:0];
        diff.dv2 = sq_v[31:0];
    end

    // threshold tests on the registered differences
    assign mag2   = 33'(stage_diff.du2) + 33'(stage_diff.dv2);
    assign motion = (stage_diff.ady >= luma_threshold) || (mag2 >= 33'(chroma_sq));

endmodule

`default_nettype wire

// ===== src/ysbu_update.sv =====
// background update: rate times difference, then add and clamp
`default_nettype none

module ysbu_update (
    input  logic [15:0]         rate,
    input  logic signed [16:0]  dy,
    input  logic signed [16:0]  du,
    input  logic signed [16:0]  dv,
    output ysbu_pkg::step_t     step,
    input  ysbu_pkg::bg_entry_t stage_bg,
    input  ysbu_pkg::step_t     stage_step,
    output ysbu_pkg::bg_entry_t new_bg
);

    import ysbu_pkg::*;

    // floor((rate * d + 32768) / 65536)
    function automatic logic signed [17:0] step_of(input logic [15:0] r,
                                                   input logic signed [16:0] d);
        logic signed [33:0] p;
        begin
            p = $signed({18'd0, r}) * 34'(d) + 34'sd32768;
            return $signed(p[33:16]);
        end
    endfunction

    // background plus step, clamped to 0..255.0
    function automatic logic [15:0] clamp_add(input logic [15:0] b,
                                              input logic signed [17:0] s);
        logic signed [18:0] n;
        logic [15:0]        res;
        begin
            n = $signed({3'b000, b}) + 19'(s);
            if (n[18])
                res = 16'd0;
            else if (n > $signed({3'b000, BG_MAX}))
                res = BG_MAX;
            else
                res = n[15:0];
            return res;
        end
    endfunction

    // products, one per channel
    always_comb
    begin
        step.sy = step_of(rate, dy);
        step.su = step_of(rate, du);
        step.sv = step_of(rate, dv);
    end

    // new entry from the registered steps
    always_comb
    begin
        new_bg.y = clamp_add(stage_bg.y, stage_step.sy);
        new_bg.u = clamp_add(stage_bg.u, stage_step.su);
        new_bg.v = clamp_add(stage_bg.v, stage_step.sv);
    end

endmodule

`default_nettype wire

// ===== src/yuv_selective_background_update.sv =====
// top level: address counter, background store, five-stage pixel pipeline
//
//   channel | handshake           | fields
//   --------+---------------------+-------------------------------------------------
//   input   | in_valid / in_ready | command, blue, green, red, load_luma,
//           |                     | load_chroma_u, load_chroma_v, frame_end
//   output  | out_valid/out_ready | motion, last_pixel (one per processed pixel)
//   config  | cfg_we              | cfg_index, cfg_data (no read-back)
//
// one item per cycle unless stalled; items pass p1 to p5, then the output register
// a pixel whose address is still held by one of the five stages waits until that
// entry is written back, so frames of five pixels or fewer lose the full rate
// reset clears control and the address counter; the store holds no valid bits
// and needs no clearing pass; the user must load an entry before a pixel reads it
// (not enforced); a stalled output lets the five stages fill before in_ready drops
`default_nettype none

module yuv_selective_background_update (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [7:0]  blue,
    input  logic [7:0]  green,
    input  logic [7:0]  red,
    input  logic [15:0] load_luma,
    input  logic [15:0] load_chroma_u,
    input  logic [15:0] load_chroma_v,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        motion,
    output logic        last_pixel,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    import ysbu_pkg::*;

    // configuration
    logic [15:0] luma_thr_reg;
    logic [15:0] chroma_thr_reg;
    logic [15:0] rate_static_reg;
    logic [15:0] rate_moving_reg;
    logic [31:0] chroma_sq_reg;

    // address counter
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;

    // store
    bg_entry_t bg_mem [STORE_DEPTH];
    bg_entry_t rd_data_reg;

    // stage registers
    ctl_t       p1_ctl_reg, p2_ctl_reg, p3_ctl_reg, p4_ctl_reg, p5_ctl_reg;
    logic [7:0] p1_blue_reg, p1_red_reg, p1_luma_reg;
    bg_entry_t  p1_load_reg;
    logic [7:0] p2_luma_reg, p2_u_reg, p2_v_reg;
    bg_entry_t  p2_bg_reg, p3_bg_reg, p4_bg_reg, p5_bg_reg;
    diff_t      p3_diff_reg;
    logic signed [16:0] p4_dy_reg, p4_du_reg, p4_dv_reg;
    logic       p4_motion_reg, p5_motion_reg;
    logic [15:0] p4_rate_reg;
    step_t      p5_step_reg;

    // output register
    logic out_valid_reg;
    logic motion_reg;
    logic last_pixel_reg;

    // unit outputs
    logic [7:0] luma_c, u_c, v_c;
    diff_t      diff_c;
    logic       motion_c;
    step_t      step_c;
    bg_entry_t  new_bg_c;

    // flow control
    logic out_free, p5_go, en1, en2, en3, en4, en5;
    logic hazard, in_fire;

    // datapath units
    ysbu_yuv u_yuv (
        .blue       (blue),
        .green      (green),
        .red        (red),
        .luma       (luma_c),
        .stage_blue (p1_blue_reg),
        .stage_red  (p1_red_reg),
        .stage_luma (p1_luma_reg),
        .chroma_u   (u_c),
        .chroma_v   (v_c)
    );

    ysbu_detect u_detect (
        .luma           (p2_luma_reg),
        .chroma_u       (p2_u_reg),
        .chroma_v       (p2_v_reg),
        .bg             (p2_bg_reg),
        .diff           (diff_c),
        .stage_diff     (p3_diff_reg),
        .luma_threshold (luma_thr_reg),
        .chroma_sq      (chroma_sq_reg),
        .motion         (motion_c)
    );

    ysbu_update u_update (
        .rate       (p4_rate_reg),
        .dy         (p4_dy_reg),
        .du         (p4_du_reg),
        .dv         (p4_dv_reg),
        .step       (step_c),
        .stage_bg   (p5_bg_reg),
        .stage_step (p5_step_reg),
        .new_bg     (new_bg_c)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            luma_thr_reg    <= LUMA_THR_RESET;
            chroma_thr_reg  <= CHROMA_THR_RESET;
            rate_static_reg <= RATE_STATIC_RESET;
            rate_moving_reg <= RATE_MOVING_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_LUMA_THR:    luma_thr_reg    <= cfg_data;
                REG_CHROMA_THR:  chroma_thr_reg  <= cfg_data;
                REG_RATE_STATIC: rate_static_reg <= cfg_data;
                REG_RATE_MOVING: rate_moving_reg <= cfg_data;
            endcase
        end
    end

    // squared chroma threshold, follows its register in the next cycle
    always_ff @(posedge clk)
    begin
        chroma_sq_reg <= 32'(chroma_thr_reg) * 32'(chroma_thr_reg);
    end

    // stage enables: a stage moves when empty or when its successor moves
    always_comb
    begin
        out_free = !out_valid_reg || out_ready;
        p5_go    = p5_ctl_reg.valid && (p5_ctl_reg.cmd == CMD_LOAD || out_free);
        en5      = !p5_ctl_reg.valid || p5_go;
        en4      = !p4_ctl_reg.valid || en5;
        en3      = !p3_ctl_reg.valid || en4;
        en2      = !p2_ctl_reg.valid || en3;
        en1      = !p1_ctl_reg.valid || en2;
    end

    // a pixel waits while its entry is still on its way back to the store
    always_comb
    begin
        hazard = (cmd_t'(command) == CMD_PROCESS) && (
                 (p1_ctl_reg.valid && p1_ctl_reg.addr == addr_reg) ||
                 (p2_ctl_reg.valid && p2_ctl_reg.addr == addr_reg) ||
                 (p3_ctl_reg.valid && p3_ctl_reg.addr == addr_reg) ||
                 (p4_ctl_reg.valid && p4_ctl_reg.addr == addr_reg) ||
                 (p5_ctl_reg.valid && p5_ctl_reg.addr == addr_reg));
        in_ready = en1 && !hazard;
        in_fire  = in_valid && in_ready;
    end

    // address advance, wraps on frame end or frame size
    always_comb
    begin
        if (frame_end || (32'(addr_reg) + 32'd1) == 32'(FRAME_PIXELS))
            addr_next = '0;
        else
            addr_next = addr_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            addr_reg <= '0;
        else if (in_fire)
            addr_reg <= addr_next;
    end

    // store read at entry, write-back from the last stage
    always_ff @(posedge clk)
    begin
        if (in_fire)
            rd_data_reg <= bg_mem[addr_reg];
        if (p5_go)
            bg_mem[p5_ctl_reg.addr] <= (p5_ctl_reg.cmd == CMD_LOAD) ? p5_bg_reg : new_bg_c;
    end

    // stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_ctl_reg    <= '0;
            p2_ctl_reg    <= '0;
            p3_ctl_reg    <= '0;
            p4_ctl_reg    <= '0;
            p5_ctl_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                p1_ctl_reg.valid     <= in_fire;
                p1_ctl_reg.cmd       <= cmd_t'(command);
                p1_ctl_reg.frame_end <= frame_end;
                p1_ctl_reg.addr      <= addr_reg;
            end
            if (en2)
                p2_ctl_reg <= p1_ctl_reg;
            if (en3)
                p3_ctl_reg <= p2_ctl_reg;
            if (en4)
                p4_ctl_reg <= p3_ctl_reg;
            if (en5)
                p5_ctl_reg <= p4_ctl_reg;
            if (out_free)
                out_valid_reg <= p5_ctl_reg.valid && (p5_ctl_reg.cmd == CMD_PROCESS);
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        // stage 1: luma and item fields
        if (in_fire)
        begin
            p1_blue_reg   <= blue;
            p1_red_reg    <= red;
            p1_luma_reg   <= luma_c;
            p1_load_reg.y <= load_luma;
            p1_load_reg.u <= load_chroma_u;
            p1_load_reg.v <= load_chroma_v;
        end
        // stage 2: chroma, background or load entry
        if (en2 && p1_ctl_reg.valid)
        begin
            p2_luma_reg <= p1_luma_reg;
            p2_u_reg    <= u_c;
            p2_v_reg    <= v_c;
            p2_bg_reg   <= (p1_ctl_reg.cmd == CMD_LOAD) ? p1_load_reg : rd_data_reg;
        end
        // stage 3: differences and squares
        if (en3 && p2_ctl_reg.valid)
        begin
            p3_diff_reg <= diff_c;
            p3_bg_reg   <= p2_bg_reg;
        end
        // stage 4: motion decision and rate
        if (en4 && p3_ctl_reg.valid)
        begin
            p4_dy_reg     <= p3_diff_reg.dy;
            p4_du_reg     <= p3_diff_reg.du;
            p4_dv_reg     <= p3_diff_reg.dv;
            p4_motion_reg <= motion_c;
            p4_rate_reg   <= motion_c ? rate_moving_reg : rate_static_reg;
            p4_bg_reg     <= p3_bg_reg;
        end
        // stage 5: update steps
        if (en5 && p4_ctl_reg.valid)
        begin
            p5_step_reg   <= step_c;
            p5_motion_reg <= p4_motion_reg;
            p5_bg_reg     <= p4_bg_reg;
        end
        // output register
        if (out_free)
        begin
            motion_reg     <= p5_motion_reg;
            last_pixel_reg <= p5_ctl_reg.frame_end;
        end
    end

    assign out_valid  = out_valid_reg;
    assign motion     = motion_reg;
    assign last_pixel = last_pixel_reg;

    // a blocked last stage keeps its item
    a_p5_hold: assert property (@(posedge clk) disable iff (!rst_n)
        p5_ctl_reg.valid && !p5_go |=> $stable(p5_ctl_reg))
        else $error("last stage item changed while blocked");

    // never read an entry in the cycle it is written back
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && cmd_t'(command) == CMD_PROCESS && p5_go |-> p5_ctl_reg.addr != addr_reg)
        else $error("pixel read its entry during write-back");

    // frame end restarts the address counter
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && frame_end |=> addr_reg == '0)
        else $error("address did not wrap on frame end");

    // a new result comes only from a processed pixel leaving the last stage
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(p5_ctl_reg.valid && p5_ctl_reg.cmd == CMD_PROCESS))
        else $error("result without a processed pixel");

endmodule

`default_nettype wire

// ===== verif/tb_yuv_selective_background_update.sv =====
// self-checking testbench for the yuv selective background update block
`default_nettype none

module tb_yuv_selective_background_update;
    import ysbu_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_COUNT   = 6;
    localparam int PHASE_ITEMS   = 182;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_AT       = 230;
    localparam int HOLD_CYCLES   = 500;

    // one input item as it appears on the ports
    typedef struct packed {
        cmd_t        cmd;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [15:0] luma;
        logic [15:0] chroma_u;
        logic [15:0] chroma_v;
        logic        frame_end;
    } pixel_item_t;

    typedef struct packed {
        logic motion;
        logic last_pixel;
    } flags_t;

    // where a directed row takes its expectation from
    typedef enum logic {
        EXP_CALC  = 1'b0,
        EXP_FIXED = 1'b1
    } exp_src_t;

    typedef struct packed {
        pixel_item_t item;
        exp_src_t    src;
        flags_t      flags;
    } stim_row_t;

    // directed items: store loads at addresses 0..7, then pixels against them
    localparam stim_row_t DIRECTED_ROWS [25] = '{
        // black, white, all-zero and all-full entries; camera fields ignored on a load
        '{'{CMD_LOAD, 8'd255, 8'd255, 8'd255, 16'd0, 16'd32768, 16'd32768, 1'b0}, EXP_CALC, '0},
        '{'{CMD_LOAD, 8'd0, 8'd0, 8'd0, 16'd65280, 16'd32768, 16'd32768, 1'b0}, EXP_CALC, '0},
        '{'{CMD_LOAD, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 1'b0}, EXP_CALC, '0},
        '{'{CMD_LOAD, 8'd0, 8'd0, 8'd0, 16'd65280, 16'd65280, 16'd65280, 1'b0}, EXP_CALC, '0},
        // luma exactly at and just under the threshold
        '{'{CMD_LOAD, 8'd0, 8'd0, 8'd0, 16'd20480, 16'd32768, 16'd32768, 1'b0}, EXP_CALC, '0},
        '{'{CMD_LOAD, 8'd0, 8'd0, 8'd0, 16'd20481, 16'd32768, 16'd32768, 1'b0}, EXP_CALC, '0},
        // chroma distance exactly at and just under the threshold
        '{'{CMD_LOAD, 8'd0, 8'd0, 8'd0, 16'd25600, 16'd30208, 16'd32768, 1'b0}, EXP_CALC, '0},
        '{'{CMD_LOAD, 8'd0, 8'd0, 8'd0, 16'd25600, 16'd30209, 16'd32768, 1'b1}, EXP_CALC, '0},
        // black and white against matching backgrounds, then against zero and full chroma
        '{'{CMD_PROCESS, 8'd0, 8'd0, 8'd0, 16'd65280, 16'd65280, 16'd65280, 1'b0},
          EXP_FIXED, '{1'b0, 1'b0}},
        '{'{CMD_PROCESS, 8'd255, 8'd255, 8'd255, 16'd0, 16'd0, 16'd0, 1'b0},
          EXP_FIXED, '{1'b0, 1'b0}},
        '{'{CMD_PROCESS, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 1'b0},
          EXP_FIXED, '{1'b1, 1'b0}},
        '{'{CMD_PROCESS, 8'd255, 8'd255, 8'd255, 16'd0, 16'd0, 16'd0, 1'b0},
          EXP_FIXED, '{1'b1, 1'b0}},
        // gray 100 against the threshold edges
        '{'{CMD_PROCESS, 8'd100, 8'd100, 8'd100, 16'd0, 16'd0, 16'd0, 1'b0},
          EXP_FIXED, '{1'b1, 1'b0}},
        '{'{CMD_PROCESS, 8'd100, 8'd100, 8'd100, 16'd0, 16'd0, 16'd0, 1'b0},
          EXP_FIXED, '{1'b0, 1'b0}},
        '{'{CMD_PROCESS, 8'd100, 8'd100, 8'd100, 16'd0, 16'd0, 16'd0, 1'b0},
          EXP_FIXED, '{1'b1, 1'b0}},
        '{'{CMD_PROCESS, 8'd100, 8'd100, 8'd100, 16'd0, 16'd0, 16'd0, 1'b1},
          EXP_FIXED, '{1'b0, 1'b1}},
        // saturated colors, v clips high on red and low on cyan
        '{'{CMD_PROCESS, 8'd0, 8'd0, 8'd255, 16'd0, 16'd0, 16'd0, 1'b0}, EXP_CALC, '0},
        '{'{CMD_PROCESS, 8'd255, 8'd255, 8'd0, 16'd0, 16'd0, 16'd0, 1'b0}, EXP_CALC, '0},
        '{'{CMD_PROCESS, 8'd255, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 1'b0}, EXP_CALC, '0},
        '{'{CMD_PROCESS, 8'd0, 8'd255, 8'd0, 16'd0, 16'd0, 16'd0, 1'b1}, EXP_CALC, '0},
        // one-pixel frames hit the same entry back to back
        '{'{CMD_LOAD, 8'd170, 8'd85, 8'd170, 16'd255, 16'd32513, 16'd32896, 1'b1}, EXP_CALC, '0},
        '{'{CMD_PROCESS, 8'd128, 8'd128, 8'd128, 16'd65280, 16'd0, 16'd65280, 1'b1},
          EXP_CALC, '0},
        '{'{CMD_PROCESS, 8'd128, 8'd128, 8'd128, 16'd0, 16'd0, 16'd0, 1'b1}, EXP_CALC, '0},
        '{'{CMD_PROCESS, 8'd255, 8'd0, 8'd255, 16'd0, 16'd0, 16'd0, 1'b1}, EXP_CALC, '0},
        '{'{CMD_PROCESS, 8'd1, 8'd2, 8'd3, 16'd0, 16'd0, 16'd0, 1'b0}, EXP_CALC, '0}
    };

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic        command       = 1'b0;
    logic [7:0]  blue          = '0;
    logic [7:0]  green         = '0;
    logic [7:0]  red           = '0;
    logic [15:0] load_luma     = '0;
    logic [15:0] load_chroma_u = '0;
    logic [15:0] load_chroma_v = '0;
    logic        frame_end     = 1'b0;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic        motion;
    logic        last_pixel;
    logic        cfg_we        = 1'b0;
    logic [1:0]  cfg_index     = REG_LUMA_THR;
    logic [15:0] cfg_data      = '0;

    // predicted state of the block
    bg_entry_t         bg_mem    [STORE_DEPTH];
    bit                bg_loaded [STORE_DEPTH];
    logic [ADDR_W-1:0] pix_addr    = '0;
    logic [15:0]       thr_luma    = LUMA_THR_RESET;
    logic [15:0]       thr_chroma  = CHROMA_THR_RESET;
    logic [15:0]       rate_still  = RATE_STATIC_RESET;
    logic [15:0]       rate_motion = RATE_MOVING_RESET;

    // last camera pixel tied to each entry, so later pixels can stay close to it
    bit [23:0] seen_pixel [STORE_DEPTH];

    flags_t pending_flags [$];

    int send_idle_pct = 22;
    int recv_idle_pct = 62;
    int fail_count    = 0;
    int results_taken = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int cycle_count   = 0;

    always #1 clk = ~clk;

    yuv_selective_background_update uut (.*);

    function automatic int clampi(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // bgr to 8-bit yuv, 14-bit coefficients, rounded and saturated
    function automatic void pixel_to_yuv(input logic [7:0] b, input logic [7:0] g,
                                         input logic [7:0] r, output int y, output int u,
                                         output int v);
        int tu;
        int tv;
        y  = (4899 * int'(r) + 9617 * int'(g) + 1868 * int'(b) + 8192) >>> 14;
        tu = (int'(b) - y) * 8061 + 128 * 16384 + 8192;
        tv = (int'(r) - y) * 14369 + 128 * 16384 + 8192;
        u  = (tu < 0) ? 0 : clampi(tu / 16384, 0, 255);
        v  = (tv < 0) ? 0 : clampi(tv / 16384, 0, 255);
    endfunction

    // move one channel by rate * diff, halves round up, clamp to 0..255.0
    function automatic logic [15:0] nudge_channel(input logic [15:0] bg, input int diff,
                                                  input logic [15:0] rate);
        longint prod;
        longint nv;
        prod = longint'(rate) * longint'(diff) + 64'sd32768;
        nv   = longint'(bg) + (prod >>> 16);
        if (nv < 0)
            nv = 0;
        if (nv > longint'(BG_MAX))
            nv = longint'(BG_MAX);
        return nv[15:0];
    endfunction

    // apply one accepted item to the predicted store and address counter
    function automatic void update_background(input pixel_item_t it, output bit has_result,
                                              output bit moving);
        int        y;
        int        u;
        int        v;
        int        dy;
        int        du;
        int        dv;
        int        ady;
        longint    mag2;
        longint    thr2;
        logic [15:0] rate;
        bg_entry_t e;
        has_result = 1'b0;
        moving     = 1'b0;
        e          = bg_mem[pix_addr];
        if (it.cmd == CMD_LOAD)
        begin
            e.y = it.luma;
            e.u = it.chroma_u;
            e.v = it.chroma_v;
            bg_mem[pix_addr]    = e;
            bg_loaded[pix_addr] = 1'b1;
        end
        else
        begin
            pixel_to_yuv(it.blue, it.green, it.red, y, u, v);
            dy   = y * 256 - int'(e.y);
            du   = u * 256 - int'(e.u);
            dv   = v * 256 - int'(e.v);
            ady  = (dy < 0) ? -dy : dy;
            mag2 = longint'(du) * du + longint'(dv) * dv;
            thr2 = longint'(thr_chroma) * longint'(thr_chroma);
            moving = (ady >= int'(thr_luma)) || (mag2 >= thr2);
            rate = moving ? rate_motion : rate_still;
            e.y  = nudge_channel(e.y, dy, rate);
            e.u  = nudge_channel(e.u, du, rate);
            e.v  = nudge_channel(e.v, dv, rate);
            bg_mem[pix_addr] = e;
            has_result = 1'b1;
        end
        if (it.frame_end || int'(pix_addr) + 1 == FRAME_PIXELS)
            pix_addr = '0;
        else
            pix_addr = pix_addr + 1'b1;
    endfunction

    function automatic logic [7:0] jitter8(input logic [7:0] c, input int j);
        return 8'(clampi(int'(c) + int'($urandom_range(0, 2 * j)) - j, 0, 255));
    endfunction

    // random item for the next address; loads mostly match a real pixel
    function automatic pixel_item_t random_item(input bit last, input bit allow_process);
        pixel_item_t it;
        bit [23:0]   px;
        int          y;
        int          u;
        int          v;
        it.cmd       = CMD_PROCESS;
        it.blue      = 8'($urandom);
        it.green     = 8'($urandom);
        it.red       = 8'($urandom);
        it.luma      = 16'($urandom_range(0, 65280));
        it.chroma_u  = 16'($urandom_range(0, 65280));
        it.chroma_v  = 16'($urandom_range(0, 65280));
        it.frame_end = last;
        if (!allow_process || !bg_loaded[pix_addr] || $urandom_range(4) == 0)
            it.cmd = CMD_LOAD;
        if (it.cmd == CMD_LOAD)
        begin
            if ($urandom_range(9) < 7)
            begin
                px = 24'($urandom);
                pixel_to_yuv(px[23:16], px[15:8], px[7:0], y, u, v);
                it.luma     = 16'(clampi(y * 256 + int'($urandom_range(0, 800)) - 400, 0, 65280));
                it.chroma_u = 16'(clampi(u * 256 + int'($urandom_range(0, 800)) - 400, 0, 65280));
                it.chroma_v = 16'(clampi(v * 256 + int'($urandom_range(0, 800)) - 400, 0, 65280));
                seen_pixel[pix_addr] = px;
            end
        end
        else
        begin
            case ($urandom_range(9))
                0:
                    px = {($urandom_range(1) != 0) ? 8'hFF : 8'h00,
                          ($urandom_range(1) != 0) ? 8'hFF : 8'h00,
                          ($urandom_range(1) != 0) ? 8'hFF : 8'h00};
                1, 2, 3, 4, 5:
                    px = {jitter8(seen_pixel[pix_addr][23:16], 6),
                          jitter8(seen_pixel[pix_addr][15:8], 6),
                          jitter8(seen_pixel[pix_addr][7:0], 6)};
                default:
                    px = 24'($urandom);
            endcase
            it.blue  = px[23:16];
            it.green = px[15:8];
            it.red   = px[7:0];
            seen_pixel[pix_addr] = px;
        end
        return it;
    endfunction

    // offer one item, hold it until taken, then record what it should produce
    task automatic send_item(input pixel_item_t it, input exp_src_t src, input flags_t fixed);
        bit     has_result;
        bit     moving;
        flags_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        command       <= it.cmd;
        blue          <= it.blue;
        green         <= it.green;
        red           <= it.red;
        load_luma     <= it.luma;
        load_chroma_u <= it.chroma_u;
        load_chroma_v <= it.chroma_v;
        frame_end     <= it.frame_end;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        update_background(it, has_result, moving);
        if (has_result)
        begin
            want.motion     = moving;
            want.last_pixel = it.frame_end;
            if (src == EXP_FIXED)
                want = fixed;
            pending_flags = {pending_flags, want};
        end
    endtask

    // let every pending result and any trailing load leave the pipeline
    task automatic wait_for_drain();
        while (pending_flags.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic [15:0] lt, input logic [15:0] ct,
                                input logic [15:0] rs, input logic [15:0] rm);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LUMA_THR;
        cfg_data  <= lt;
        @(posedge clk);
        thr_luma   = lt;
        cfg_index <= REG_CHROMA_THR;
        cfg_data  <= ct;
        @(posedge clk);
        thr_chroma = ct;
        cfg_index <= REG_RATE_STATIC;
        cfg_data  <= rs;
        @(posedge clk);
        rate_still = rs;
        cfg_index <= REG_RATE_MOVING;
        cfg_data  <= rm;
        @(posedge clk);
        rate_motion = rm;
        cfg_we    <= 1'b0;
    endtask

    // main sequence
    initial
    begin
        logic [15:0] phase_regs [PHASE_COUNT][4];
        int          sent;
        int          frame_len;
        bit          last;
        phase_regs[0] = '{16'd1024, 16'd768, 16'd16384, 16'd2048};
        phase_regs[1] = '{16'd0, 16'd0, 16'd0, 16'd65535};
        phase_regs[2] = '{16'd65535, 16'd65535, 16'd65535, 16'd0};
        phase_regs[3] = '{16'($urandom_range(0, 8192)), 16'($urandom_range(0, 8192)),
                          16'($urandom), 16'($urandom)};
        phase_regs[4] = '{16'd768, 16'd512, 16'd32768, 16'd4096};
        phase_regs[5] = '{16'($urandom), 16'($urandom_range(0, 4096)),
                          16'($urandom), 16'($urandom)};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows under reset configuration
        for (int i = 0; i < 25; i++)
            send_item(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].src, DIRECTED_ROWS[i].flags);
        in_valid <= 1'b0;

        // random frames, one register setting and idle pattern per phase
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            wait_for_drain();
            if (p < 2)
            begin
                send_idle_pct = 22;
                recv_idle_pct = 62;
            end
            else if (p < 4)
            begin
                send_idle_pct = 62;
                recv_idle_pct = 22;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            program_regs(phase_regs[p][0], phase_regs[p][1], phase_regs[p][2],
                         phase_regs[p][3]);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                frame_len = ($urandom_range(9) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 12);
                for (int k = 0; k < frame_len; k++)
                begin
                    last = (k == frame_len - 1);
                    // occasionally break the framing
                    if ($urandom_range(19) == 0)
                        last = !last;
                    send_item(random_item(last, 1'b1), EXP_CALC, '0);
                    sent++;
                end
            end
            in_valid <= 1'b0;
        end

        wait_for_drain();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // result receiver, with one long hold-off to back the pipeline up
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            results_taken++;
        if (!hold_done && results_taken == HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // compare each result item with the oldest expectation
    always @(posedge clk)
    begin
        flags_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_flags.size() == 0)
            begin
                $error("unexpected result: motion %0d last_pixel %0d", motion, last_pixel);
                fail_count++;
            end
            else
            begin
                want = pending_flags.pop_front();
                if (motion !== want.motion)
                begin
                    $error("motion: expected %0d, got %0d", want.motion, motion);
                    fail_count++;
                end
                if (last_pixel !== want.last_pixel)
                begin
                    $error("last_pixel: expected %0d, got %0d", want.last_pixel, last_pixel);
                    fail_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule

`default_nettype wire
